[hdl/ace_window_contrast_filter_core_macros.svh]
// assertion macros for the ace window contrast filter
// no dependencies; included by the top level
`ifndef ACE_WINDOW_CONTRAST_FILTER_CORE_MACROS_SVH
`define ACE_WINDOW_CONTRAST_FILTER_CORE_MACROS_SVH
`ifndef SYNTH
`define ACEWCF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("acewcf assertion failed");
`define ACEWCF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("acewcf assertion failed");
`else
`define ACEWCF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ACEWCF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/acewcf_pkg.sv]
// shared types, constants and weight functions of the ace window filter
// no dependencies
package acewcf_pkg;

    localparam int KW     = 21;
    localparam int HMAX   = 1024;
    localparam int HW     = 11;
    localparam int GW     = 8;
    localparam int PXW    = 8;
    localparam int CW     = 17;
    localparam int WTW    = 16;
    localparam int ACC_W  = 26;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 11;

    localparam logic [CFG_IW-1:0] CFG_SLOPE_GAIN   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [GW-1:0] GAIN_RST   = 8'd4;
    localparam logic [HW-1:0] WIDTH_RST  = 11'd640;
    localparam logic [HW-1:0] HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic issue;
        logic inframe;
        logic center;
        logic clear;
    } mac_ctl_t;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q = '0;
        rem = '0;
        for (int s = 63; s >= 0; s--)
        begin
            rem = {rem[62:0], num[s]};
            if (rem >= den)
            begin
                rem = rem - den;
                q[s] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int s = 0; s < 32; s++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int s = 0; s < 32; s++)
        begin
            if (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] inv_dist(input int di, input int dj);
        logic [63:0] n;
        n = 64'(di * di + dj * dj);
        if (n == 0)
            return '0;
        return isqrt64(udiv64(64'h4000_0000_0000_0000, n));
    endfunction

    function automatic logic [63:0] inv_total(input int radius);
        logic [63:0] t;
        t = '0;
        for (int i = -radius; i <= radius; i++)
        begin
            for (int j = -radius; j <= radius; j++)
                t = t + inv_dist(i, j);
        end
        return t;
    endfunction

    function automatic logic [63:0] tap_weight(input int di, input int dj,
                                               input logic [63:0] total);
        logic [63:0] num;
        num = (inv_dist(di, dj) << 16) + (total >> 1);
        return udiv64(num, total);
    endfunction

endpackage

[hdl/acewcf_pix_if.sv]
// pixel input channel: valid, ready, mode and pixel value
// depends on acewcf_pkg
interface acewcf_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [acewcf_pkg::PXW-1:0]   pixel_value;
    modport source (output valid, output mode, output pixel_value, input ready);
    modport sink (input valid, input mode, input pixel_value, output ready);
endinterface

[hdl/acewcf_res_if.sv]
// result output channel: valid, ready, contrast value and frame end
// depends on acewcf_pkg
interface acewcf_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [acewcf_pkg::CW-1:0] contrast_value;
    logic                             frame_end;
    modport source (output valid, output contrast_value, output frame_end, input ready);
    modport sink (input valid, input contrast_value, input frame_end, output ready);
endinterface

[hdl/acewcf_cfg_if.sv]
// configuration write channel: valid, ready, register index and data
// depends on acewcf_pkg
interface acewcf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [acewcf_pkg::CFG_IW-1:0]   index;
    logic [acewcf_pkg::CFG_DW-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/acewcf_store.sv]
// line store: one write port, one read port, registered read data
// no dependencies
module acewcf_store #(
    parameter int DEPTH = 15360,
    parameter int AW    = 14,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[hdl/acewcf_mac.sv]
// window multiply-accumulate pipeline: difference, gain, clamp, weight, sum
// depends on acewcf_pkg
module acewcf_mac #(
    parameter int RADIUS = 7,
    parameter int TW     = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  acewcf_pkg::mac_ctl_t                   ctl,
    input  logic [TW-1:0]                          tap,
    input  logic [acewcf_pkg::PXW-1:0]             rd_data,
    input  logic [acewcf_pkg::GW-1:0]              gain,
    output logic signed [acewcf_pkg::ACC_W-1:0]    acc,
    output logic                                   busy
);
    import acewcf_pkg::*;

    localparam int WIN  = 2 * RADIUS + 1;
    localparam int TAPS = WIN * WIN;
    localparam int PW1  = PXW + GW + 2;
    localparam logic [63:0] TOTAL = inv_total(RADIUS);

    logic [WTW-1:0] wtab [TAPS];

    for (genvar g = 0; g < TAPS; g++)
    begin : g_wt
        localparam int DI = g / WIN - RADIUS;
        localparam int DJ = g % WIN - RADIUS;
        assign wtab[g] = WTW'(tap_weight(DI, DJ, TOTAL));
    end

    logic                    s1_v_reg, s2_v_reg, s3_v_reg, s1_ctr_reg;
    logic                    s1_in_reg;
    logic [TW-1:0]           s1_tap_reg, s2_tap_reg;
    logic [PXW-1:0]          p_reg;
    logic signed [PW1-1:0]   s2_prod_reg;
    logic signed [ACC_W-1:0] s3_prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic [PXW-1:0]          q;
    logic signed [PXW:0]     diff;
    logic signed [PW1-1:0]   prod1;
    logic signed [PXW:0]     clamped;
    logic signed [ACC_W-1:0] prod2;

    assign q     = s1_in_reg ? rd_data : '0;
    assign diff  = $signed({1'b0, p_reg}) - $signed({1'b0, q});
    assign prod1 = diff * $signed({1'b0, gain});

    always_comb
    begin
        if (s2_prod_reg > $signed(PW1'(255)))
            clamped = $signed((PXW + 1)'(255));
        else if (s2_prod_reg < -$signed(PW1'(255)))
            clamped = -$signed((PXW + 1)'(255));
        else
            clamped = s2_prod_reg[PXW:0];
    end

    assign prod2 = clamped * $signed({1'b0, wtab[s2_tap_reg]});

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
            acc_next = '0;
        else if (s3_v_reg)
            acc_next = acc_reg + s3_prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            s1_ctr_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            s1_v_reg   <= ctl.issue;
            s2_v_reg   <= s1_v_reg;
            s3_v_reg   <= s2_v_reg;
            s1_ctr_reg <= ctl.center;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_in_reg   <= ctl.inframe;
        s1_tap_reg  <= tap;
        s2_tap_reg  <= s1_tap_reg;
        s2_prod_reg <= prod1;
        s3_prod_reg <= prod2;
        if (s1_ctr_reg)
            p_reg <= rd_data;
    end

    assign acc  = acc_reg;
    assign busy = s1_v_reg | s2_v_reg | s3_v_reg;

endmodule

[hdl/ace_window_contrast_filter_core.sv]
// top level of the ace window contrast filter: sequencer, counters, config
// depends on acewcf_pkg, the channel interfaces, acewcf_store, acewcf_mac
//
// channel   role    transaction
// pix_in    sink    mode, pixel_value
// res_out   source  contrast_value, frame_end
// cfg       sink    index, data (slope_gain, frame_width, frame_height)
//
// an item without a result passes through accept and decide (store write)
// an item with a result goes through accept, decide, start, walk, flush and finish; the window is
// read one pixel per cycle through the single read port of the line store
// a register write holds off pix_in, through cfg_pend_reg, while the geometry settles
// reset clears control and config; the line store is not cleared
// a held result does not block the next transaction on pix_in
`include "ace_window_contrast_filter_core_macros.svh"
module ace_window_contrast_filter_core #(
    parameter int RADIUS    = 7,
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    acewcf_pix_if.sink  pix_in,
    acewcf_res_if.source res_out,
    acewcf_cfg_if.sink  cfg
);
    import acewcf_pkg::*;

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int TAPS  = WIN * WIN;
    localparam int TW    = $clog2(TAPS);
    localparam int JW    = $clog2(WIN);
    localparam int DEPTH = WIN * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int PW    = WW + HW;
    localparam int LW    = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int SW    = ((WW > HW) ? WW : HW) + 2;
    localparam int XW0   = (KW > PW) ? KW : PW;
    localparam int XW    = ((XW0 > LW) ? XW0 : LW) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [GW-1:0]        gain_reg, gain_next;
    logic [HW-1:0]        fw_reg, fw_next, fh_reg, fh_next;
    logic [WW-1:0]        w_eff_reg, w_eff_next;
    logic [HW-1:0]        h_eff_reg, h_eff_next;
    logic [PW-1:0]        npix_reg, npix_next;
    logic [LW-1:0]        lag_reg, lag_next;
    logic [KW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        wa_reg, wa_next, ca_reg, ca_next;
    logic [AW-1:0]        na_reg, na_next, row_reg, row_next;
    logic [HW-1:0]        r_reg, r_next;
    logic [WW-1:0]        c_reg, c_next;
    logic signed [SW-1:0] ri_reg, ri_next, ci_reg, ci_next;
    logic [TW-1:0]        tap_reg, tap_next;
    logic [JW-1:0]        tj_reg, tj_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 mode_reg;
    logic [PXW-1:0]       pix_reg;
    logic signed [CW-1:0] res_value_reg, res_value_next;
    logic                 res_end_reg, res_end_next;
    logic [1:0]           cfg_pend_reg, cfg_pend_next;

    logic [XW-1:0]        k_ext, lag_ext, npix_ext;
    logic                 in_frame_k, emit, last_px, res_load, tap_in, pix_acc;
    logic [AW-1:0]        wa_inc, ca_inc, na_inc;
    logic [AW:0]          row_sum, row_wrap, ca_x, lag_a, na_start;
    logic signed [SW-1:0] h_s, w_s, c_start;

    mac_ctl_t                ctl;
    logic [PXW-1:0]          rd_data;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_busy;
    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_raddr;

    // effective frame geometry
    always_comb
    begin
        if (fw_reg == '0)
            w_eff_next = WW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w_eff_next = WW'(MAX_WIDTH);
        else
            w_eff_next = WW'(fw_reg);
        if (fh_reg == '0)
            h_eff_next = HW'(1);
        else if (32'(fh_reg) > HMAX)
            h_eff_next = HW'(HMAX);
        else
            h_eff_next = fh_reg;
    end

    assign npix_next = PW'(w_eff_reg) * PW'(h_eff_reg);
    assign lag_next  = LW'(RADIUS) * LW'(w_eff_reg) + LW'(RADIUS);

    assign pix_acc       = pix_in.valid && pix_in.ready;
    assign cfg_pend_next = {cfg_pend_reg[0], cfg.valid && cfg.ready};

    assign k_ext      = XW'(cnt_reg);
    assign lag_ext    = XW'(lag_reg);
    assign npix_ext   = XW'(npix_reg);
    assign in_frame_k = k_ext < npix_ext;
    assign emit       = (k_ext >= lag_ext) && ((k_ext - lag_ext) < npix_ext);
    assign last_px    = (r_reg == HW'(h_eff_reg - 1'b1)) && (c_reg == WW'(w_eff_reg - 1'b1));

    assign wa_inc = (32'(wa_reg) == DEPTH - 1) ? '0 : AW'(wa_reg + 1'b1);
    assign ca_inc = (32'(ca_reg) == DEPTH - 1) ? '0 : AW'(ca_reg + 1'b1);
    assign na_inc = (32'(na_reg) == DEPTH - 1) ? '0 : AW'(na_reg + 1'b1);

    assign row_sum  = {1'b0, row_reg} + (AW + 1)'(w_eff_reg);
    assign row_wrap = (32'(row_sum) >= DEPTH) ? row_sum - (AW + 1)'(DEPTH) : row_sum;
    assign ca_x     = {1'b0, ca_reg};
    assign lag_a    = (AW + 1)'(lag_reg);
    assign na_start = (ca_x >= lag_a) ? ca_x - lag_a : ca_x + (AW + 1)'(DEPTH) - lag_a;

    assign h_s     = $signed(SW'(h_eff_reg));
    assign w_s     = $signed(SW'(w_eff_reg));
    assign c_start = $signed(SW'(c_reg)) - $signed(SW'(RADIUS));
    assign tap_in  = !ri_reg[SW-1] && (ri_reg < h_s) && !ci_reg[SW-1] && (ci_reg < w_s);

    assign res_load = (state_reg == ST_FINISH) && (!res_valid_reg || res_out.ready);

    always_comb
    begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        fw_next        = fw_reg;
        fh_next        = fh_reg;
        cnt_next       = cnt_reg;
        wa_next        = wa_reg;
        ca_next        = ca_reg;
        na_next        = na_reg;
        row_next       = row_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        ri_next        = ri_reg;
        ci_next        = ci_reg;
        tap_next       = tap_reg;
        tj_next        = tj_reg;
        res_valid_next = res_valid_reg;
        res_value_next = res_value_reg;
        res_end_next   = res_end_reg;

        if (res_valid_reg && res_out.ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_acc)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (in_frame_k && mode_reg)
                    state_next = ST_IDLE;
                else if (emit)
                    state_next = ST_START;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    wa_next    = wa_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                na_next    = na_start[AW-1:0];
                row_next   = na_start[AW-1:0];
                ri_next    = $signed(SW'(r_reg)) - $signed(SW'(RADIUS));
                ci_next    = c_start;
                tap_next   = '0;
                tj_next    = '0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (32'(tj_reg) == WIN - 1)
                begin
                    tj_next  = '0;
                    na_next  = row_wrap[AW-1:0];
                    row_next = row_wrap[AW-1:0];
                    ri_next  = ri_reg + $signed(SW'(1));
                    ci_next  = c_start;
                end
                else
                begin
                    tj_next = tj_reg + 1'b1;
                    na_next = na_inc;
                    ci_next = ci_reg + $signed(SW'(1));
                end
                tap_next = tap_reg + 1'b1;
                if (32'(tap_reg) == TAPS - 1)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (!mac_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    res_value_next = mac_acc[CW+7:8];
                    res_end_next   = last_px;
                    state_next     = ST_IDLE;
                    if (last_px)
                    begin
                        cnt_next = '0;
                        wa_next  = '0;
                        ca_next  = '0;
                        r_next   = '0;
                        c_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        wa_next  = wa_inc;
                        ca_next  = ca_inc;
                        if (c_reg == WW'(w_eff_reg - 1'b1))
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                            c_next = c_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // register writes must arrive only while idle; the block itself does not enforce this
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SLOPE_GAIN:
                begin
                    gain_next = cfg.data[GW-1:0];
                end
                CFG_FRAME_WIDTH:
                begin
                    fw_next  = cfg.data;
                    cnt_next = '0;
                    wa_next  = '0;
                    ca_next  = '0;
                    r_next   = '0;
                    c_next   = '0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    fh_next  = cfg.data;
                    cnt_next = '0;
                    wa_next  = '0;
                    ca_next  = '0;
                    r_next   = '0;
                    c_next   = '0;
                end
                default:
                begin
                    gain_next = gain_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_RST;
            fw_reg        <= WIDTH_RST;
            fh_reg        <= HEIGHT_RST;
            w_eff_reg     <= WW'(WIDTH_RST);
            h_eff_reg     <= HEIGHT_RST;
            npix_reg      <= PW'(WIDTH_RST) * PW'(HEIGHT_RST);
            lag_reg       <= LW'(RADIUS) * LW'(WIDTH_RST) + LW'(RADIUS);
            cnt_reg       <= '0;
            wa_reg        <= '0;
            ca_reg        <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            res_valid_reg <= 1'b0;
            cfg_pend_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            w_eff_reg     <= w_eff_next;
            h_eff_reg     <= h_eff_next;
            npix_reg      <= npix_next;
            lag_reg       <= lag_next;
            cnt_reg       <= cnt_next;
            wa_reg        <= wa_next;
            ca_reg        <= ca_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            res_valid_reg <= res_valid_next;
            cfg_pend_reg  <= cfg_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg        <= na_next;
        row_reg       <= row_next;
        ri_reg        <= ri_next;
        ci_reg        <= ci_next;
        tap_reg       <= tap_next;
        tj_reg        <= tj_next;
        res_value_reg <= res_value_next;
        res_end_reg   <= res_end_next;
        if (pix_acc)
        begin
            mode_reg <= pix_in.mode;
            pix_reg  <= pix_in.pixel_value;
        end
    end

    assign mem_we    = (state_reg == ST_DECIDE) && in_frame_k && !mode_reg;
    assign mem_re    = (state_reg == ST_START) || (state_reg == ST_WALK);
    assign mem_raddr = (state_reg == ST_START) ? ca_reg : na_reg;

    assign ctl.issue   = (state_reg == ST_WALK);
    assign ctl.inframe = tap_in;
    assign ctl.center  = (state_reg == ST_START);
    assign ctl.clear   = (state_reg == ST_START);

    acewcf_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PXW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wa_reg),
        .wdata (pix_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    acewcf_mac #(
        .RADIUS (RADIUS),
        .TW     (TW)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .tap     (tap_reg),
        .rd_data (rd_data),
        .gain    (gain_reg),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    assign pix_in.ready           = (state_reg == ST_IDLE) && !cfg.valid && (cfg_pend_reg == '0);
    assign cfg.ready              = 1'b1;
    assign res_out.valid          = res_valid_reg;
    assign res_out.contrast_value = res_value_reg;
    assign res_out.frame_end      = res_end_reg;

    `ACEWCF_ASSERT_IMP(a_walk_addr, clk, rst_n, state_reg == ST_WALK, 32'(na_reg) < DEPTH)
    `ACEWCF_ASSERT_IMP(a_idle_drained, clk, rst_n, state_reg == ST_IDLE, !mac_busy)
    `ACEWCF_ASSERT_NXT(a_frame_restart, clk, rst_n, res_load && last_px, cnt_reg == '0 && r_reg == '0 && c_reg == '0)

endmodule
